>>> rtl/core/crc8_frame_receiver_unit_assert.svh
// Assertion macros for the CRC-8 frame receiver RTL.
`ifndef CRC8_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC8FR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8fr same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRC8FR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8fr next-cycle assertion failed");

`endif

>>> rtl/core/crc8fr_pkg.sv
// Package with types, constants and the CRC step of the CRC-8 frame receiver.
`timescale 1ns / 1ps
package crc8fr_pkg;

    localparam logic [7:0] START_BYTE     = 8'hAA;
    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd255;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd200;
    localparam int         QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        CMD_ARM  = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_ARM  = 2'd0,
        CLS_BYTE = 2'd1,
        CLS_TICK = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_START = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_CRC      = 3'd4,
        ST_ZERO_MAX = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } kind_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] data;
    } q_entry_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crc8fr_if.sv
// Stream interfaces for incoming items and outgoing results.
`timescale 1ns / 1ps
interface crc8fr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface crc8fr_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic [7:0] frame_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output status, output frame_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input status, input frame_length, output ready);
endinterface

>>> rtl/core/crc8fr_queue.sv
// Small register queue between the front and back parts.
`timescale 1ns / 1ps
module crc8fr_queue #(
    parameter int DEPTH = crc8fr_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  crc8fr_pkg::q_entry_t       push_entry,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output crc8fr_pkg::q_entry_t       head,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    crc8fr_pkg::q_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (level_reg == LVL_W'(DEPTH));
    assign head_valid = (level_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end
endmodule

>>> rtl/core/crc8fr_front.sv
// Front part: accepts items, classifies the command and drops unused codes.
`timescale 1ns / 1ps
module crc8fr_front (
    crc8fr_item_if.sink                item,
    input  logic                       q_full,
    output logic                       push,
    output crc8fr_pkg::q_entry_t       push_entry
);
    crc8fr_pkg::cmd_t cmd;
    logic             keep;

    assign cmd        = crc8fr_pkg::cmd_t'(item.command);
    assign item.ready = !q_full;
    assign push       = item.valid && !q_full && keep;

    always_comb
    begin
        keep            = 1'b1;
        push_entry.cls  = crc8fr_pkg::CLS_TICK;
        push_entry.data = item.rx_byte;
        case (cmd)
            crc8fr_pkg::CMD_ARM:  push_entry.cls = crc8fr_pkg::CLS_ARM;
            crc8fr_pkg::CMD_BYTE: push_entry.cls = crc8fr_pkg::CLS_BYTE;
            crc8fr_pkg::CMD_TICK: push_entry.cls = crc8fr_pkg::CLS_TICK;
            default:              keep           = 1'b0;
        endcase
    end
endmodule

>>> rtl/core/crc8fr_back.sv
// Back part: frame state machine, CRC check, timeout and the result register.
`timescale 1ns / 1ps
module crc8fr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  crc8fr_pkg::q_entry_t head,
    output logic                 pop,
    input  logic [7:0]           max_length,
    input  logic [7:0]           timeout_ticks,
    crc8fr_result_if.source      result
);
    crc8fr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] ticks_reg, ticks_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] taken_reg, taken_next;
    logic [7:0] crc_reg, crc_next;
    logic       res_valid_reg, res_valid_next;

    crc8fr_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]          data_reg, data_next;
    logic [7:0]          index_reg, index_next;
    crc8fr_pkg::status_t status_reg, status_next;
    logic [7:0]          flen_reg, flen_next;
    logic                emit;
    logic                fire;

    assign fire = head_valid && (!res_valid_reg || result.ready);
    assign pop  = fire;

    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        len_next    = len_reg;
        taken_next  = taken_reg;
        crc_next    = crc_reg;
        emit        = 1'b0;
        kind_next   = crc8fr_pkg::KIND_END;
        data_next   = '0;
        index_next  = '0;
        status_next = crc8fr_pkg::ST_OK;
        flen_next   = '0;
        case (head.cls)
            crc8fr_pkg::CLS_ARM:
            begin
                len_next   = '0;
                taken_next = '0;
                crc_next   = '0;
                if (max_length == '0)
                begin
                    emit        = 1'b1;
                    status_next = crc8fr_pkg::ST_ZERO_MAX;
                    phase_next  = crc8fr_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = crc8fr_pkg::PH_HUNT;
                    ticks_next = timeout_ticks;
                end
            end
            crc8fr_pkg::CLS_TICK:
            begin
                if (phase_reg != crc8fr_pkg::PH_IDLE)
                begin
                    if (ticks_reg <= 8'd1)
                    begin
                        ticks_next  = '0;
                        emit        = 1'b1;
                        status_next = (phase_reg == crc8fr_pkg::PH_HUNT) ?
                                      crc8fr_pkg::ST_NO_START : crc8fr_pkg::ST_TIMEOUT;
                        phase_next  = crc8fr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end
            end
            crc8fr_pkg::CLS_BYTE:
            begin
                case (phase_reg)
                    crc8fr_pkg::PH_HUNT:
                    begin
                        if (head.data == crc8fr_pkg::START_BYTE)
                        begin
                            phase_next = crc8fr_pkg::PH_LENGTH;
                            ticks_next = timeout_ticks;
                        end
                    end
                    crc8fr_pkg::PH_LENGTH:
                    begin
                        if (head.data == '0 || head.data > max_length)
                        begin
                            emit        = 1'b1;
                            status_next = crc8fr_pkg::ST_BAD_LEN;
                            phase_next  = crc8fr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            len_next   = head.data;
                            taken_next = '0;
                            crc_next   = '0;
                            ticks_next = timeout_ticks;
                            phase_next = crc8fr_pkg::PH_PAYLOAD;
                        end
                    end
                    crc8fr_pkg::PH_PAYLOAD:
                    begin
                        emit       = 1'b1;
                        kind_next  = crc8fr_pkg::KIND_PAYLOAD;
                        data_next  = head.data;
                        index_next = taken_reg;
                        crc_next   = crc8fr_pkg::crc8_update(crc_reg, head.data);
                        taken_next = taken_reg + 8'd1;
                        ticks_next = timeout_ticks;
                        if (taken_next >= len_reg)
                        begin
                            phase_next = crc8fr_pkg::PH_CRC;
                        end
                    end
                    crc8fr_pkg::PH_CRC:
                    begin
                        emit       = 1'b1;
                        phase_next = crc8fr_pkg::PH_IDLE;
                        if (head.data != crc_reg)
                        begin
                            status_next = crc8fr_pkg::ST_CRC;
                        end
                        else
                        begin
                            flen_next = len_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (fire)
        begin
            res_valid_next = emit;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= crc8fr_pkg::PH_IDLE;
            ticks_reg     <= '0;
            len_reg       <= '0;
            taken_reg     <= '0;
            crc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                ticks_reg <= ticks_next;
                len_reg   <= len_next;
                taken_reg <= taken_next;
                crc_reg   <= crc_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            index_reg  <= index_next;
            status_reg <= status_next;
            flen_reg   <= flen_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.kind         = kind_reg;
    assign result.data_byte    = data_reg;
    assign result.byte_index   = index_reg;
    assign result.status       = status_reg;
    assign result.frame_length = flen_reg;
endmodule

>>> rtl/core/crc8_frame_receiver_unit.sv
// After its item transfer, a result passes through the queue and then the result register.
// Throughput: one item per cycle while result back-pressure does not stall the back part.
// Unused commands are dropped at the front; other items that cause no result still take
// one queue slot and are processed by the back part.
// Reset is asynchronous and active low: the frame state goes idle, the queue and result
// register empty, max_length returns to 255 and timeout_ticks to 200.
`timescale 1ns / 1ps
`include "crc8_frame_receiver_unit_assert.svh"
module crc8_frame_receiver_unit #(
    parameter int QUEUE_DEPTH = crc8fr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    crc8fr_item_if.sink       item,
    crc8fr_result_if.source   result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]           max_length_reg;
    logic [7:0]           timeout_ticks_reg;
    logic                 cfg_write;
    logic                 q_push;
    crc8fr_pkg::q_entry_t q_push_entry;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_head_valid;
    crc8fr_pkg::q_entry_t q_head;
    logic [LVL_W-1:0]     q_level;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {24'd0, timeout_ticks_reg} : {24'd0, max_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg    <= crc8fr_pkg::MAX_LEN_RESET;
            timeout_ticks_reg <= crc8fr_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                timeout_ticks_reg <= pwdata[7:0];
            end
            else
            begin
                max_length_reg <= pwdata[7:0];
            end
        end
    end

    crc8fr_front u_front (
        .item       (item),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    crc8fr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head),
        .level      (q_level)
    );

    crc8fr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .max_length    (max_length_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (result)
    );

    `CRC8FR_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, q_level <= LVL_W'(QUEUE_DEPTH))
    `CRC8FR_ASSERT_NXT(a_empty_stays, clk, rst_n,
        (q_level == '0) && !(item.valid && item.ready), q_level == '0)
    `CRC8FR_ASSERT_IMP(a_payload_clean, clk, rst_n,
        result.valid && (result.kind == crc8fr_pkg::KIND_PAYLOAD),
        (result.status == crc8fr_pkg::ST_OK) && (result.frame_length == '0))
    `CRC8FR_ASSERT_IMP(a_ok_has_length, clk, rst_n,
        result.valid && (result.kind == crc8fr_pkg::KIND_END)
            && (result.status == crc8fr_pkg::ST_OK),
        result.frame_length != '0)
endmodule

>>> sim/crc8fr_tb_pkg.sv
// Register addresses and the CRC step shared by the frame receiver testbench modules.
`timescale 1ns / 1ps
package crc8fr_tb_pkg;

    import crc8fr_pkg::*;

    typedef enum logic [2:0] {
        REG_MAX_LENGTH    = 3'd0,
        REG_TIMEOUT_TICKS = 3'd4
    } reg_addr_t;

    // Bit-serial form of the non-reflected CRC-8, fed most significant bit first.
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0};
            if (fb)
            begin
                acc ^= CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

>>> sim/crc8fr_checker.sv
// Checker that predicts the frame receiver results from observed transfers and compares them.
`timescale 1ns / 1ps
module crc8fr_checker (
    input  logic        clk,
    input  logic        rst_n,
    crc8fr_item_if      item,
    crc8fr_result_if    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          payload_checked,
    output int          ends_clean,
    output int          ends_error
);

    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        status_t    status;
        logic [7:0] frame_length;
    } rx_result_t;

    logic [7:0] max_length_reg;
    logic [7:0] timeout_reg;
    phase_t     rx_phase;
    logic [7:0] ticks_left;
    logic [7:0] frame_len;
    logic [7:0] bytes_taken;
    logic [7:0] crc_acc;
    rx_result_t frame_results_due[$];
    rx_result_t due;

    function automatic rx_result_t frame_end(input status_t st, input logic [7:0] len);
        rx_result_t r;
        r              = '0;
        r.kind         = KIND_END;
        r.status       = st;
        r.frame_length = len;
        return r;
    endfunction

    task automatic end_frame(input status_t st, input logic [7:0] len);
        frame_results_due.push_back(frame_end(st, len));
        rx_phase = PH_IDLE;
    endtask

    task automatic receive_step(input cmd_t cmd, input logic [7:0] b);
        rx_result_t r;
        r = '0;
        if (cmd == CMD_ARM)
        begin
            frame_len   = 8'd0;
            bytes_taken = 8'd0;
            crc_acc     = 8'd0;
            if (max_length_reg == 8'd0)
            begin
                end_frame(ST_ZERO_MAX, 8'd0);
            end
            else
            begin
                rx_phase   = PH_HUNT;
                ticks_left = timeout_reg;
            end
        end
        else if (rx_phase != PH_IDLE && cmd == CMD_TICK)
        begin
            if (ticks_left <= 8'd1)
            begin
                ticks_left = 8'd0;
                if (rx_phase == PH_HUNT)
                begin
                    end_frame(ST_NO_START, 8'd0);
                end
                else
                begin
                    end_frame(ST_TIMEOUT, 8'd0);
                end
            end
            else
            begin
                ticks_left--;
            end
        end
        else if (rx_phase != PH_IDLE && cmd == CMD_BYTE)
        begin
            case (rx_phase)
                PH_HUNT:
                begin
                    if (b == START_BYTE)
                    begin
                        rx_phase   = PH_LENGTH;
                        ticks_left = timeout_reg;
                    end
                end
                PH_LENGTH:
                begin
                    if (b == 8'd0 || b > max_length_reg)
                    begin
                        end_frame(ST_BAD_LEN, 8'd0);
                    end
                    else
                    begin
                        frame_len   = b;
                        bytes_taken = 8'd0;
                        crc_acc     = 8'd0;
                        ticks_left  = timeout_reg;
                        rx_phase    = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.kind       = KIND_PAYLOAD;
                    r.data_byte  = b;
                    r.byte_index = bytes_taken;
                    frame_results_due.push_back(r);
                    crc_acc     = crc8_step(crc_acc, b);
                    bytes_taken = bytes_taken + 8'd1;
                    ticks_left  = timeout_reg;
                    if (bytes_taken >= frame_len)
                    begin
                        rx_phase = PH_CRC;
                    end
                end
                default:
                begin
                    if (b != crc_acc)
                    begin
                        end_frame(ST_CRC, 8'd0);
                    end
                    else
                    begin
                        end_frame(ST_OK, frame_len);
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg  = MAX_LEN_RESET;
            timeout_reg     = TIMEOUT_RESET;
            rx_phase        = PH_IDLE;
            ticks_left      = 8'd0;
            frame_len       = 8'd0;
            bytes_taken     = 8'd0;
            crc_acc         = 8'd0;
            fail_count      = 0;
            payload_checked = 0;
            ends_clean      = 0;
            ends_error      = 0;
            frame_results_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_addr_t'(paddr))
                    REG_MAX_LENGTH:    max_length_reg = pwdata[7:0];
                    REG_TIMEOUT_TICKS: timeout_reg    = pwdata[7:0];
                    default:           ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("Result transfer with no result outstanding: kind %0d status %0d",
                           result.kind, result.status);
                    fail_count++;
                end
                else
                begin
                    due = frame_results_due.pop_front();
                    check_field("kind", due.kind, result.kind);
                    check_field("data_byte", due.data_byte, result.data_byte);
                    check_field("byte_index", due.byte_index, result.byte_index);
                    check_field("status", due.status, result.status);
                    check_field("frame_length", due.frame_length, result.frame_length);
                    if (due.kind == KIND_PAYLOAD)
                    begin
                        payload_checked++;
                    end
                    else if (due.status == ST_OK)
                    begin
                        ends_clean++;
                    end
                    else
                    begin
                        ends_error++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                receive_step(cmd_t'(item.command), item.rx_byte);
            end
            pending <= frame_results_due.size();
        end
    end

endmodule

>>> sim/tb.sv
// Top of the frame receiver testbench: clock, reset, register setup, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int src_idle_pct;
    int sink_stall_pct;
    int items_sent;
    int quiet_cycles;
    int gen_max;
    int gen_timeout;
    int fail_count;
    int pending;
    int payload_checked;
    int ends_clean;
    int ends_error;

    crc8fr_item_if   item_ch();
    crc8fr_result_if result_ch();

    crc8_frame_receiver_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    crc8fr_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .payload_checked (payload_checked),
        .ends_clean      (ends_clean),
        .ends_error      (ends_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("crc8_frame_receiver_unit regression: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == START_BYTE)
        begin
            b = ~b;
        end
        return b;
    endfunction

    function automatic int pick_len();
        if (gen_max <= 0)
        begin
            return 0;
        end
        if ($urandom_range(39) == 0)
        begin
            return (gen_max < 40) ? gen_max : 40;
        end
        return $urandom_range(1, (gen_max < 8) ? gen_max : 8);
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // The sender holds off until every predicted result has been taken.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_addr_t addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_MAX_LENGTH)
        begin
            gen_max = value;
        end
        else
        begin
            gen_timeout = value;
        end
    endtask

    task automatic configure(input logic [7:0] max_len, input logic [7:0] ticks);
        wait_idle();
        write_reg(REG_MAX_LENGTH, max_len);
        write_reg(REG_TIMEOUT_TICKS, ticks);
    endtask

    // A frame with hunt noise; a cut below len stops it before the CRC byte.
    task automatic send_frame(input int len, input bit good_crc, input int cut);
        logic [7:0] acc;
        logic [7:0] b;
        acc = 8'h00;
        send_item(CMD_ARM, 8'($urandom));
        repeat ($urandom_range(2)) send_item(CMD_BYTE, noise_byte());
        if ($urandom_range(9) == 0)
        begin
            send_item(CMD_TICK, 8'($urandom));
        end
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_BYTE, 8'(len));
        for (int i = 0; i < len && i < cut; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_item(CMD_TICK, 8'($urandom));
            end
            b   = 8'($urandom);
            acc = crc8_step(acc, b);
            send_item(CMD_BYTE, b);
        end
        if (cut >= len)
        begin
            send_item(CMD_BYTE, good_crc ? acc : (acc ^ 8'($urandom_range(1, 255))));
        end
    endtask

    task automatic random_traffic();
        int pick;
        int len;
        int n;
        pick = $urandom_range(99);
        len  = pick_len();
        if (pick < 70 && len > 0)
        begin
            send_frame(len, $urandom_range(9) != 0, len);
        end
        else if (pick < 78)
        begin
            send_item(CMD_ARM, 8'($urandom));
            send_item(CMD_BYTE, START_BYTE);
            if (gen_max < 255 && $urandom_range(1) == 1)
            begin
                send_item(CMD_BYTE, 8'($urandom_range(gen_max + 1, 255)));
            end
            else
            begin
                send_item(CMD_BYTE, 8'd0);
            end
        end
        else if (pick < 86 && len > 0)
        begin
            send_frame(len, 1'b1, $urandom_range(0, len - 1));
        end
        else if (pick < 92 && gen_timeout <= 16 && gen_max > 0)
        begin
            send_item(CMD_ARM, 8'($urandom));
            if ($urandom_range(1) == 1)
            begin
                send_item(CMD_BYTE, START_BYTE);
                if ($urandom_range(1) == 1)
                begin
                    send_item(CMD_BYTE, 8'($urandom_range(1, gen_max)));
                end
            end
            n = (gen_timeout == 0) ? 1 : gen_timeout;
            repeat (n) send_item(CMD_TICK, 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4)) send_item(cmd_t'($urandom_range(3)), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        item_ch.valid   = 1'b0;
        item_ch.command = CMD_NONE;
        item_ch.rx_byte = 8'd0;
        result_ch.ready = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        gen_max         = MAX_LEN_RESET;
        gen_timeout     = TIMEOUT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks under the reset settings, then with zero limits.
        send_item(CMD_BYTE, 8'h55);
        send_item(CMD_NONE, 8'hFF);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_NONE, START_BYTE);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_BYTE, 8'd2);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, crc8_step(crc8_step(8'h00, 8'hFF), 8'h00) ^ 8'h01);
        send_item(CMD_ARM, 8'hFF);
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_BYTE, 8'd0);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_BYTE, 8'd1);
        send_item(CMD_BYTE, 8'h80);
        send_item(CMD_BYTE, crc8_step(8'h00, 8'h80));
        configure(8'd0, TIMEOUT_RESET);
        send_item(CMD_ARM, 8'h00);
        configure(8'd3, 8'd0);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_ARM, 8'h00);
        send_item(CMD_BYTE, START_BYTE);
        send_item(CMD_TICK, 8'h00);

        configure(8'd255, 8'd4);
        send_frame(255, 1'b1, 255);
        while (items_sent < 330)
        begin
            random_traffic();
        end

        configure(8'd9, 8'd255);
        src_idle_pct = 77;
        while (items_sent < 630)
        begin
            random_traffic();
        end

        configure(8'd255, 8'd2);
        src_idle_pct   = 0;
        sink_stall_pct = 77;
        while (items_sent < 930)
        begin
            random_traffic();
        end

        configure(8'd40, 8'd1);
        src_idle_pct   = 7;
        sink_stall_pct = 7;
        while (items_sent < 1250)
        begin
            random_traffic();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Run covered %0d input transfers: %0d payload bytes, %0d clean frame ends",
                 items_sent, payload_checked, ends_clean);
        $display("and %0d error ends, over seven register settings and four idling mixes.",
                 ends_error);
        if (fail_count == 0)
        begin
            $display("crc8_frame_receiver_unit regression: pass");
        end
        else
        begin
            $display("crc8_frame_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
